// ===== hdl/slri_pkg.sv =====
package slri_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int ACT_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 5;
    // value, status, fill packed from bit 0, padded to whole bytes
    localparam int OUT_DATA_W   = ((KEY_W + STATUS_W + FILL_W + 7) / 8) * 8;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_VIEW   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t op;
        key_t     key;
    } cell_ctrl_t;

    // what a cell shows its neighbours
    typedef struct packed {
        key_t key;
        logic valid;
    } cell_link_t;

endpackage

// ===== hdl/slri_cell.sv =====
module slri_cell
    import slri_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       prev_less,
    input  cell_link_t prev_link,
    input  cell_link_t next_link,
    input  key_t       head_key,
    output cell_link_t link,
    output logic       less
);

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;

    assign less      = valid_reg && (key_reg < ctrl.key);
    assign link.key   = key_reg;
    assign link.valid = valid_reg;

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                // keep if smaller, take new key at the boundary, else shift up
                if (less) begin
                    key_next = key_reg;
                end else if (prev_less) begin
                    key_next   = ctrl.key;
                    valid_next = 1'b1;
                end else begin
                    key_next   = prev_link.key;
                    valid_next = prev_link.valid;
                end
            end
            CELL_REMOVE: begin
                // from the first key not below the match onward, shift down
                if (valid_reg && !less) begin
                    key_next   = next_link.key;
                    valid_next = next_link.valid;
                end
            end
            CELL_ROTATE: begin
                // last valid cell wraps round to the head
                if (valid_reg) begin
                    key_next = next_link.valid ? next_link.key : head_key;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
    end

endmodule

// ===== hdl/sorted_list_insert_remove.sv =====
// Sorted key list: holds up to CAPACITY signed Q16.16 keys in ascending order in a row of
// compare-and-shift cells. Each request carries an action in s_tuser (0 insert, 1 remove
// first equal key, 2 view, 3 no operation) and a key in s_tdata. Insert, remove and the
// no-op give one result each; an insert into a full list is refused with status full, a
// remove without a match gives status not found. View of N stored keys gives N results,
// smallest first, tlast on the final one: the chain rotates by one cell per cycle while
// the output register is free or being drained, the head cell feeds the output register,
// and input is held off until the final key has been loaded. View of an empty list gives a
// single result with status empty. Each result also reports the fill after the action.
// The next request is taken as soon as the output register is free or being drained.
module sorted_list_insert_remove
    import slri_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KEY_W-1:0]      s_tdata,   // key[31:0]
    input  logic [ACT_W-1:0]      s_tuser,   // action[1:0]
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // value[31:0], status[33:32], fill[38:34], pad
    output logic                  m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_VIEW
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] rem_reg;     // keys still to emit during a view
    logic [CNT_W-1:0] rem_next;

    // output register
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    key_t                value_reg;
    key_t                value_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                last_reg;
    logic                last_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;

    cell_ctrl_t           ctrl;
    cell_link_t           links    [CAPACITY];
    logic [CAPACITY-1:0]  less_vec;
    logic [CAPACITY-1:0]  valid_vec;
    logic [CAPACITY-1:0]  match_vec;
    logic [CAPACITY:0]    valid_ext;
    logic                 found;
    logic                 full;
    logic                 out_free;
    logic                 accept;
    action_t              action;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic       prev_less;
        cell_link_t prev_link;
        cell_link_t next_link;

        if (i == 0) begin : g_head
            assign prev_less = 1'b1;   // head always sees the boundary above it
            assign prev_link = '{key: '0, valid: 1'b1};
        end else begin : g_mid
            assign prev_less = less_vec[i-1];
            assign prev_link = links[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_link = '{key: '0, valid: 1'b0};
        end else begin : g_body
            assign next_link = links[i+1];
        end

        slri_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .prev_less (prev_less),
            .prev_link (prev_link),
            .next_link (next_link),
            .head_key  (links[0].key),
            .link      (links[i]),
            .less      (less_vec[i])
        );

        assign valid_vec[i] = links[i].valid;
        assign match_vec[i] = links[i].valid && (links[i].key == ctrl.key);
    end

    assign found     = |match_vec;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign valid_ext = {1'b0, valid_vec};

    // ---------------- handshake ----------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign action   = action_t'(s_tuser);

    // ---------------- control ----------------
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rem_next      = rem_reg;
        ctrl.op       = CELL_HOLD;
        ctrl.key      = key_t'(s_tdata);
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        fill_next     = fill_reg;

        if (state_reg == S_VIEW) begin
            if (out_free) begin
                ctrl.op       = CELL_ROTATE;
                m_tvalid_next = 1'b1;
                value_next    = links[0].key;
                status_next   = ST_OK;
                last_next     = (rem_reg == CNT_W'(1));
                fill_next     = FILL_W'(count_reg);
                rem_next      = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1)) begin
                    state_next = S_IDLE;
                end
            end
        end else if (accept) begin
            m_tvalid_next = 1'b1;
            value_next    = '0;
            status_next   = ST_OK;
            last_next     = 1'b1;
            unique case (action)
                ACT_INSERT: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        ctrl.op    = CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_REMOVE: begin
                    if (found) begin
                        ctrl.op    = CELL_REMOVE;
                        count_next = count_reg - CNT_W'(1);
                    end else begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                ACT_VIEW: begin
                    if (count_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else begin
                        // first key is loaded into the output register on accept
                        ctrl.op    = CELL_ROTATE;
                        value_next = links[0].key;
                        last_next  = (count_reg == CNT_W'(1));
                        rem_next   = count_reg - CNT_W'(1);
                        if (count_reg != CNT_W'(1)) begin
                            state_next = S_VIEW;
                        end
                    end
                end
                ACT_NOP: begin
                end
                default: begin
                end
            endcase
            fill_next = FILL_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rem_reg      <= rem_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        fill_reg   <= fill_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = OUT_DATA_W'({fill_reg, status_reg, value_reg});

    // ---------------- assertions ----------------
    // key count tracks the cells' valid bits
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == count_reg)
        else $error("key count differs from valid cells");

    // valid cells form an unbroken run from the head
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_ext + 1'b1) & valid_ext) == '0)
        else $error("gap in valid cells");

    // no request taken while a view is being emitted
    a_no_accept_in_view: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_VIEW) |-> !s_tready)
        else $error("request accepted during view");

    // view ends with a last result
    a_view_ends_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_VIEW && state_next == S_IDLE) |=> (m_tvalid && m_tlast))
        else $error("view finished without last");

endmodule

// ===== sim/tb_sorted_list_insert_remove.sv =====
module tb_sorted_list_insert_remove
    import slri_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP             = CAPACITY_DEF;
    localparam int RANDOM_REQUESTS = 390;
    localparam int POOL_DEPTH      = 32;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 50;

    // result word layout: value, status, fill from bit 0
    localparam int STATUS_LSB = KEY_W;
    localparam int FILL_LSB   = KEY_W + STATUS_W;

    typedef struct {
        action_t action;
        key_t    key;
    } list_request_t;

    typedef struct {
        key_t                value;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic [FILL_W-1:0]   fill;
    } list_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [KEY_W-1:0]      s_tdata  = '0;   // key[31:0]
    logic [ACT_W-1:0]      s_tuser  = '0;   // action[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // value[31:0], status[33:32], fill[38:34], pad
    logic                  m_tlast;

    sorted_list_insert_remove #(
        .CAPACITY (CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // requests waiting to be offered, and results owed by the block, oldest first
    list_request_t pending_requests[$];
    list_result_t  owed_results[$];
    // most recent keys sent for insert; removes mostly draw on these so that they hit
    key_t          inserted_keys[$];

    // shadow copy of the list
    key_t          list_keys[CAP];
    int            list_count = 0;

    int            total_requests = 0;
    int            accepted_count = 0;
    int            error_count    = 0;
    logic          rx_hold        = 1'b0;
    list_request_t next_req;
    list_result_t  exp_res;

    // ------------------------------------------------------------------
    // Predictor: applies one accepted request to the shadow list and
    // appends the results it must produce.
    // ------------------------------------------------------------------
    task automatic apply_request(action_t act, key_t k);
        int           pos;
        list_result_t res;
        res = '{value: '0, status: ST_OK, last: 1'b1, fill: '0};
        case (act)
            ACT_INSERT: begin
                if (list_count >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    // goes in front of the first key not less than it, so
                    // a new key lands ahead of any equal keys already held
                    pos = 0;
                    while (pos < list_count && list_keys[pos] < k)
                        pos++;
                    for (int i = list_count; i > pos; i--)
                        list_keys[i] = list_keys[i-1];
                    list_keys[pos] = k;
                    list_count++;
                end
                res.fill = FILL_W'(list_count);
                owed_results.push_back(res);
            end
            ACT_REMOVE: begin
                pos = 0;
                while (pos < list_count && list_keys[pos] != k)
                    pos++;
                if (pos >= list_count) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    for (int i = pos; i + 1 < list_count; i++)
                        list_keys[i] = list_keys[i+1];
                    list_count--;
                end
                res.fill = FILL_W'(list_count);
                owed_results.push_back(res);
            end
            ACT_VIEW: begin
                res.fill = FILL_W'(list_count);
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                    owed_results.push_back(res);
                end else begin
                    for (int i = 0; i < list_count; i++) begin
                        res.value = list_keys[i];
                        res.last  = (i + 1 == list_count);
                        owed_results.push_back(res);
                    end
                end
            end
            default: begin
                // no-op action: no change, one plain result
                res.fill = FILL_W'(list_count);
                owed_results.push_back(res);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_request(action_t act, key_t k);
        pending_requests.push_back('{action: act, key: k});
        if (act == ACT_INSERT) begin
            inserted_keys.push_back(k);
            if (inserted_keys.size() > POOL_DEPTH)
                void'(inserted_keys.pop_front());
        end
    endtask

    // known_pct: chance of reusing a key already sent for insert
    function automatic key_t pick_key(int unsigned known_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (inserted_keys.size() != 0 && roll < known_pct)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        case ($urandom_range(0, 3))
            0, 1:    return key_t'($urandom);
            2:       return key_t'(int'($urandom_range(0, 15)) - 8);
            default: return $urandom_range(0, 1) ? key_t'(32'h8000_0000)
                                                 : key_t'(32'h7FFF_FFFF);
        endcase
    endfunction

    // Idle rates per third of the run: receiver lazy first, then sender,
    // then neither.
    function automatic int unsigned idle_pct(bit receiver);
        int phase;
        phase = (total_requests == 0) ? 0 : (accepted_count * 3) / total_requests;
        case (phase)
            0:       return receiver ? 48 : 8;
            1:       return receiver ? 8 : 48;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the next pending request; the predictor runs at the
    // edge where a request is taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(action_t'(s_tuser), key_t'(s_tdata));
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    next_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.key;
                    s_tuser  <= next_req.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results and checks them against the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: tdata %h, tlast %b", m_tdata, m_tlast);
                    error_count++;
                end else begin
                    exp_res = owed_results.pop_front();
                    if (m_tdata[KEY_W-1:0] !== exp_res.value) begin
                        $error("value: expected %0d, got %0d",
                               exp_res.value, $signed(m_tdata[KEY_W-1:0]));
                        error_count++;
                    end
                    if (m_tdata[STATUS_LSB +: STATUS_W] !== exp_res.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_res.status, m_tdata[STATUS_LSB +: STATUS_W]);
                        error_count++;
                    end
                    if (m_tlast !== exp_res.last) begin
                        $error("last: expected %0d, got %0d", exp_res.last, m_tlast);
                        error_count++;
                    end
                    if (m_tdata[FILL_LSB +: FILL_W] !== exp_res.fill) begin
                        $error("fill: expected %0d, got %0d",
                               exp_res.fill, m_tdata[FILL_LSB +: FILL_W]);
                        error_count++;
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // Back-pressure: halfway through, the receiver stops for a long stretch
    // while the sender keeps offering, so the view output backs up and the
    // request side stalls.
    initial begin
        @(posedge aclk);
        while (total_requests == 0 || accepted_count < total_requests / 2)
            @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("sorted_list_insert_remove verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : main_seq
        int unsigned roll;
        action_t     act;
        bit          insert_heavy;

        // directed: empty cases, no-op, extremes, duplicates, misses
        queue_request(ACT_VIEW,   key_t'($urandom));     // view of empty list
        queue_request(ACT_REMOVE, key_t'(5));            // remove from empty list
        queue_request(ACT_NOP,    key_t'($urandom));
        queue_request(ACT_INSERT, key_t'(32'h8000_0000));
        queue_request(ACT_INSERT, key_t'(32'h7FFF_FFFF));
        queue_request(ACT_INSERT, key_t'(0));
        queue_request(ACT_INSERT, key_t'(-1));
        queue_request(ACT_INSERT, key_t'(0));             // duplicate
        queue_request(ACT_VIEW,   key_t'(0));
        queue_request(ACT_REMOVE, key_t'(2));             // no match
        queue_request(ACT_REMOVE, key_t'(0));             // first of the pair
        queue_request(ACT_REMOVE, key_t'(32'h7FFF_FFFF));
        queue_request(ACT_REMOVE, key_t'(32'h8000_0000));
        // fill to capacity, then one refused insert and a full view
        for (int i = 0; i < CAP - 2; i++)
            queue_request(ACT_INSERT, key_t'($urandom));
        queue_request(ACT_INSERT, key_t'($urandom));     // list full
        queue_request(ACT_VIEW,   key_t'(0));

        // random: alternate insert-heavy and remove-heavy stretches so the
        // fill swings between empty and full
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            insert_heavy = ((n / 40) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                act = ACT_NOP;
            else if (roll < 15)
                act = ACT_VIEW;
            else if (roll < (insert_heavy ? 70 : 40))
                act = ACT_INSERT;
            else
                act = ACT_REMOVE;
            queue_request(act, pick_key(act == ACT_REMOVE ? 80 : 30));
        end
        total_requests = pending_requests.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid || owed_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("sorted_list_insert_remove verification clean");
        else
            $display("sorted_list_insert_remove verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/slri_pkg.sv
hdl/slri_cell.sv
hdl/sorted_list_insert_remove.sv
sim/tb_sorted_list_insert_remove.sv
